@@ design/lfsrp_pkg.sv @@
// ----------------------------------------------------------------------------
// lfsrp_pkg
// Shared types, constants and constant tables for the GF(p) shift register
// sequence unit: prime codes, mod-p reduction table and saturated power table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsrp_pkg;

  localparam int MAX_TAPS_DEF = 20;
  localparam int LENGTH_LIMIT = 1024000;

  localparam int DIGIT_W    = 3;
  localparam int DEG_W      = 5;
  localparam int CFG_W      = 60;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_PRIMES = 4;
  localparam int DEG_SPAN   = 2 ** DEG_W;
  localparam int POW_W      = $clog2(LENGTH_LIMIT + 1);
  localparam int CNT_W      = $clog2(LENGTH_LIMIT);
  localparam int GROUP_SIZE = 5;
  localparam int TERM_MAX   = 6;
  localparam int GSUM_W     = $clog2(GROUP_SIZE * TERM_MAX + 1);
  localparam int SUM_W      = 7;
  localparam int MOD_SPAN   = 2 ** SUM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARACTERISTIC = 2'd0,
    CFG_DEGREE         = 2'd1,
    CFG_FEEDBACK       = 2'd2,
    CFG_SEED           = 2'd3
  } cfg_index_t;

  typedef logic [1:0] prime_sel_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic in_use;
    logic at_top;
  } cell_ctrl_t;

  typedef logic [NUM_PRIMES-1:0][MOD_SPAN-1:0][DIGIT_W-1:0] mod_tab_t;
  typedef logic [NUM_PRIMES-1:0][DEG_SPAN-1:0][POW_W-1:0]   pow_tab_t;

  function automatic logic [DIGIT_W-1:0] prime_value(prime_sel_t sel);
    logic [DIGIT_W-1:0] p;
    unique case (sel)
      2'd0:    p = 3'd2;
      2'd1:    p = 3'd3;
      2'd2:    p = 3'd5;
      default: p = 3'd7;
    endcase
    return p;
  endfunction

  function automatic logic prime_ok(logic [DIGIT_W-1:0] p);
    return (p == 3'd2) || (p == 3'd3) || (p == 3'd5) || (p == 3'd7);
  endfunction

  function automatic prime_sel_t prime_code(logic [DIGIT_W-1:0] p);
    prime_sel_t sel;
    unique case (p)
      3'd3:    sel = 2'd1;
      3'd5:    sel = 2'd2;
      3'd7:    sel = 2'd3;
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    int       r;
    int       p;
    for (int s = 0; s < NUM_PRIMES; s++) begin
      p = int'(prime_value(prime_sel_t'(s)));
      r = 0;
      for (int v = 0; v < MOD_SPAN; v++) begin
        t[s][v] = DIGIT_W'(r);
        r = r + 1;
        if (r == p) begin
          r = 0;
        end
      end
    end
    return t;
  endfunction

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t t;
    longint   pw;
    longint   p;
    for (int s = 0; s < NUM_PRIMES; s++) begin
      p  = longint'(prime_value(prime_sel_t'(s)));
      pw = 1;
      for (int d = 0; d < DEG_SPAN; d++) begin
        t[s][d] = POW_W'(pw);
        pw = pw * p;
        if (pw >= longint'(LENGTH_LIMIT)) begin
          pw = longint'(LENGTH_LIMIT);
        end
      end
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();
  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

@@ design/lfsrp_cell.sv @@
// ----------------------------------------------------------------------------
// lfsrp_cell
// One register cell: holds a digit and its feedback coefficient, takes the
// digit of its upper neighbor (or the feedback digit at the top) on a shift
// and offers its term (p - coeff) * digit mod p to the feedback sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsrp_cell (
  input  wire                              clk,
  input  wire lfsrp_pkg::cell_ctrl_t       ctrl,
  input  wire lfsrp_pkg::prime_sel_t       psel,
  input  wire [lfsrp_pkg::DIGIT_W-1:0]     seed_digit,
  input  wire [lfsrp_pkg::DIGIT_W-1:0]     coef_digit,
  input  wire [lfsrp_pkg::DIGIT_W-1:0]     digit_up,
  input  wire [lfsrp_pkg::DIGIT_W-1:0]     feedback,
  output logic [lfsrp_pkg::DIGIT_W-1:0]    digit,
  output logic [lfsrp_pkg::DIGIT_W-1:0]    term
);

  logic [lfsrp_pkg::DIGIT_W-1:0]     digit_r;
  logic [lfsrp_pkg::DIGIT_W-1:0]     coef_r;
  logic [lfsrp_pkg::DIGIT_W-1:0]     neg_coef;
  logic [2*lfsrp_pkg::DIGIT_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digit_r <= seed_digit;
      coef_r  <= coef_digit;
    end else if (ctrl.shift && ctrl.in_use) begin
      digit_r <= ctrl.at_top ? feedback : digit_up;
    end
  end

  assign neg_coef = lfsrp_pkg::prime_value(psel) - coef_r;
  assign prod     = {{lfsrp_pkg::DIGIT_W{1'b0}}, neg_coef} *
                    {{lfsrp_pkg::DIGIT_W{1'b0}}, digit_r};
  assign term     = ctrl.in_use ?
                    lfsrp_pkg::MOD_TAB[psel][lfsrp_pkg::SUM_W'(prod)] : '0;
  assign digit    = digit_r;

endmodule

`default_nettype wire

@@ design/lfsrp_fold.sv @@
// ----------------------------------------------------------------------------
// lfsrp_fold
// Feedback sum: adds the cell terms in groups into registers, then adds the
// group sums and reduces the total mod p into the next sequence digit.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsrp_fold #(
  parameter int NUM_TERMS = lfsrp_pkg::MAX_TAPS_DEF
) (
  input  wire                                       clk,
  input  wire                                       capture,
  input  wire lfsrp_pkg::prime_sel_t                psel,
  input  wire [NUM_TERMS-1:0][lfsrp_pkg::DIGIT_W-1:0] terms,
  output logic [lfsrp_pkg::DIGIT_W-1:0]             k
);

  localparam int NUM_GROUPS =
    (NUM_TERMS + lfsrp_pkg::GROUP_SIZE - 1) / lfsrp_pkg::GROUP_SIZE;

  logic [NUM_GROUPS-1:0][lfsrp_pkg::GSUM_W-1:0] group_r;
  logic [NUM_GROUPS-1:0][lfsrp_pkg::GSUM_W-1:0] group_nxt;
  logic [lfsrp_pkg::SUM_W-1:0]                  total;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < lfsrp_pkg::GROUP_SIZE; j++) begin
        if (g * lfsrp_pkg::GROUP_SIZE + j < NUM_TERMS) begin
          group_nxt[g] = group_nxt[g] + lfsrp_pkg::GSUM_W'(
                           terms[g * lfsrp_pkg::GROUP_SIZE + j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      group_r <= group_nxt;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + lfsrp_pkg::SUM_W'(group_r[g]);
    end
  end

  assign k = lfsrp_pkg::MOD_TAB[psel][total];

endmodule

`default_nettype wire

@@ design/lfsr_sequence_over_prime_field_unit.sv @@
// Tick steps: on acceptance the grouped term sum is registered; then the
// group add, mod-p table and shift produce the digit into the output register.
// A restart with bad settings loads its flagged result into the output register.
// A new tick or restart is accepted only in idle with the output free or taken.
// Reset (synchronous): run stopped, count zero, configuration back to p = 2,
// degree 1, zero coefficients and seed; cell contents are loaded on restart.
// ----------------------------------------------------------------------------
// lfsr_sequence_over_prime_field_unit
// Fibonacci shift register over GF(p), p in {2,3,5,7}, built as a chain of
// cells with a registered feedback sum; checks settings on restart.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsr_sequence_over_prime_field_unit #(
  parameter int MAX_TAPS = lfsrp_pkg::MAX_TAPS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [lfsrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [lfsrp_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_restart,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [lfsrp_pkg::DIGIT_W-1:0]       out_digit,
  output logic                                out_last,
  output logic                                out_bad_setting
);

  typedef enum logic {S_IDLE, S_FIN} state_t;

  localparam int DW = lfsrp_pkg::DIGIT_W;

  state_t                           state_r;
  logic [DW-1:0]                    char_r;
  logic [lfsrp_pkg::DEG_W-1:0]      degree_r;
  logic [lfsrp_pkg::CFG_W-1:0]      coeffs_r;
  logic [lfsrp_pkg::CFG_W-1:0]      seed_r;

  logic                             running_r;
  logic [lfsrp_pkg::CNT_W-1:0]      digits_left_r;
  lfsrp_pkg::prime_sel_t            run_psel_r;
  logic [lfsrp_pkg::DEG_W-1:0]      run_deg_r;
  logic                             out_valid_r;
  logic [DW-1:0]                    out_digit_r;
  logic                             out_last_r;
  logic                             out_bad_r;

  logic                             accept;
  logic                             load_run;
  logic                             capture;
  logic                             out_load;
  lfsrp_pkg::prime_sel_t            psel;
  logic                             setting_ok;
  logic [MAX_TAPS-1:0]              digit_bad;
  logic [lfsrp_pkg::POW_W-1:0]      pw;
  logic [lfsrp_pkg::CNT_W-1:0]      run_len;
  logic [DW-1:0]                    k;

  logic [MAX_TAPS-1:0][DW-1:0]      coef_dig;
  logic [MAX_TAPS-1:0][DW-1:0]      seed_dig;
  logic [MAX_TAPS-1:0][DW-1:0]      cell_digit;
  logic [MAX_TAPS-1:0][DW-1:0]      cell_term;
  lfsrp_pkg::cell_ctrl_t            cell_ctrl [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r   <= 3'd2;
      degree_r <= 5'd1;
      coeffs_r <= '0;
      seed_r   <= '0;
    end else if (cfg_we) begin
      unique case (lfsrp_pkg::cfg_index_t'(cfg_index))
        lfsrp_pkg::CFG_CHARACTERISTIC: char_r   <= cfg_wdata[DW-1:0];
        lfsrp_pkg::CFG_DEGREE:         degree_r <= cfg_wdata[lfsrp_pkg::DEG_W-1:0];
        lfsrp_pkg::CFG_FEEDBACK:       coeffs_r <= cfg_wdata;
        lfsrp_pkg::CFG_SEED:           seed_r   <= cfg_wdata;
        default:                       ;
      endcase
    end
  end

  assign psel = lfsrp_pkg::prime_code(char_r);
  assign pw   = lfsrp_pkg::POW_TAB[psel][degree_r];

  genvar i;
  generate
    for (i = 0; i < MAX_TAPS; i++) begin : g_cell
      if (DW * i + DW <= lfsrp_pkg::CFG_W) begin : g_in
        assign coef_dig[i] = coeffs_r[DW*i +: DW];
        assign seed_dig[i] = seed_r[DW*i +: DW];
      end else begin : g_zero
        assign coef_dig[i] = '0;
        assign seed_dig[i] = '0;
      end

      assign digit_bad[i] = (lfsrp_pkg::DEG_W'(i) < degree_r) &&
                            ((coef_dig[i] >= char_r) || (seed_dig[i] >= char_r));

      assign cell_ctrl[i].load   = load_run && (lfsrp_pkg::DEG_W'(i) < degree_r);
      assign cell_ctrl[i].shift  = (state_r == S_FIN);
      assign cell_ctrl[i].in_use = lfsrp_pkg::DEG_W'(i) < run_deg_r;
      assign cell_ctrl[i].at_top = lfsrp_pkg::DEG_W'(i + 1) == run_deg_r;

      if (i == MAX_TAPS - 1) begin : g_top
        lfsrp_cell u_cell (
          .clk        (clk),
          .ctrl       (cell_ctrl[i]),
          .psel       (run_psel_r),
          .seed_digit (seed_dig[i]),
          .coef_digit (coef_dig[i]),
          .digit_up   ({DW{1'b0}}),
          .feedback   (k),
          .digit      (cell_digit[i]),
          .term       (cell_term[i])
        );
      end else begin : g_mid
        lfsrp_cell u_cell (
          .clk        (clk),
          .ctrl       (cell_ctrl[i]),
          .psel       (run_psel_r),
          .seed_digit (seed_dig[i]),
          .coef_digit (coef_dig[i]),
          .digit_up   (cell_digit[i+1]),
          .feedback   (k),
          .digit      (cell_digit[i]),
          .term       (cell_term[i])
        );
      end
    end
  endgenerate

  assign setting_ok = lfsrp_pkg::prime_ok(char_r) &&
                      (degree_r <= lfsrp_pkg::DEG_W'(MAX_TAPS)) &&
                      !(|digit_bad) &&
                      (pw < lfsrp_pkg::POW_W'(lfsrp_pkg::LENGTH_LIMIT));

  assign run_len = lfsrp_pkg::CNT_W'(pw - lfsrp_pkg::POW_W'(1) -
                                     lfsrp_pkg::POW_W'(degree_r));

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign load_run = accept && in_restart && setting_ok;
  assign capture  = accept && !in_restart && running_r;
  assign out_load = (state_r == S_FIN) || (accept && in_restart && !setting_ok);

  lfsrp_fold #(
    .NUM_TERMS (MAX_TAPS)
  ) u_fold (
    .clk     (clk),
    .capture (capture),
    .psel    (run_psel_r),
    .terms   (cell_term),
    .k       (k)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      running_r     <= 1'b0;
      digits_left_r <= '0;
      run_psel_r    <= '0;
      run_deg_r     <= '0;
      out_valid_r   <= 1'b0;
      out_digit_r   <= '0;
      out_last_r    <= 1'b0;
      out_bad_r     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_restart) begin
              if (setting_ok) begin
                running_r     <= (run_len != '0);
                digits_left_r <= run_len;
                run_psel_r    <= psel;
                run_deg_r     <= degree_r;
              end else begin
                running_r     <= 1'b0;
                digits_left_r <= '0;
                out_digit_r   <= '0;
                out_last_r    <= 1'b0;
                out_bad_r     <= 1'b1;
              end
            end else if (running_r) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          out_digit_r   <= k;
          out_last_r    <= (digits_left_r == lfsrp_pkg::CNT_W'(1));
          out_bad_r     <= 1'b0;
          running_r     <= (digits_left_r != lfsrp_pkg::CNT_W'(1));
          digits_left_r <= digits_left_r - lfsrp_pkg::CNT_W'(1);
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit       = out_digit_r;
  assign out_last        = out_last_r;
  assign out_bad_setting = out_bad_r;

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (digits_left_r != '0))
    else $error("run active with zero digits left");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (running_r && !out_valid_r))
    else $error("digit step without active run or with pending result");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (out_valid_r && !out_bad_r))
    else $error("digit step did not produce a result");

  a_end_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_last_r || out_bad_r)) |-> !running_r)
    else $error("run still active after final or flagged result");

endmodule

`default_nettype wire
